[sv/rmlz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder package
// Shared constants, register indexes and state types of the decoder.
// ----------------------------------------------------------------------------
package rmlz_pkg;

    localparam int WINDOW_DEPTH_DEF      = 8192;
    localparam int LENGTH_FIELD_BITS_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_W    = 24;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECOMPRESS_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_GUARD_LIMIT  = 3'd5;

    localparam logic OPCODE_FILE   = 1'b0;
    localparam logic OPCODE_FILLER = 1'b1;

    localparam logic [BYTE_W-1:0] MASK_STEP     = 8'h07;
    localparam logic [BYTE_W-1:0] END_MARK_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] END_MARK_HIGH = 8'h80;

    localparam int LITERAL_BITS  = 8;
    localparam int MATCH_MIN_LEN = 3;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_LIT  = 2'd1,
        PH_OFF  = 2'd2,
        PH_LEN  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR       = 3'd0,
        ST_IDLE        = 3'd1,
        ST_BITS        = 3'd2,
        ST_COPY_START  = 3'd3,
        ST_COPY        = 3'd4,
        ST_FINISH      = 3'd5,
        ST_DRAIN_START = 3'd6,
        ST_DRAIN       = 3'd7
    } state_t;

endpackage

[sv/rmlz_byte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder byte channel
// Carries one encrypted file byte or filler item per transfer.
// ----------------------------------------------------------------------------
interface rmlz_byte_if;

    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output opcode, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input last_byte,
                    output ready);

endinterface

[sv/rmlz_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder result channel
// Carries one output byte with its status flags per transfer.
// ----------------------------------------------------------------------------
interface rmlz_result_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       output_done;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output output_done, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input output_done, input run_last, output ready);

endinterface

[sv/rmlz_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder RAM
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rmlz_ram #(
    parameter int DEPTH = rmlz_pkg::WINDOW_DEPTH_DEF,
    parameter int WIDTH = rmlz_pkg::BYTE_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/rolling_mask_lzss_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder core
// Decrypts file bytes with a rolling subtractive mask, passes the header
// through and decodes the LZSS bitstream into bytes, one bit per cycle between copies.
//
//   Channel      Direction  Payload
//   byte_ch      sink       opcode, data_byte, last_byte
//   result_ch    source     out_byte, byte_valid, status, output_done, run_last
//   cfg          write      cfg_wr_en, cfg_index, cfg_wdata
//
// After reset the history window is cleared one entry per cycle; no byte is
// taken during that pass.
// A header or decrypt-only byte goes from idle through drain start to the
// drain, which sends its one result. A bitstream byte is shifted out bit by
// bit, with a copy pass for each match that is not cut short, then goes
// through finish and, with results or an end check, drain start and drain.
// A stalled result channel holds the drain, and holds the last result in the
// output register while the next byte is taken.
// ----------------------------------------------------------------------------
module rolling_mask_lzss_decoder_core #(
    parameter int WINDOW_DEPTH      = rmlz_pkg::WINDOW_DEPTH_DEF,
    parameter int LENGTH_FIELD_BITS = rmlz_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rmlz_byte_if.sink                        byte_ch,
    rmlz_result_if.source                    result_ch,
    input  logic                             cfg_wr_en,
    input  logic [rmlz_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmlz_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import rmlz_pkg::*;

    localparam int WIN_AW    = $clog2(WINDOW_DEPTH);
    localparam int BL_W      = $clog2(WIN_AW + 1);
    localparam int CNT_W     = LENGTH_FIELD_BITS + 1;
    localparam int RES_DEPTH = (2 ** LENGTH_FIELD_BITS) + 2;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_W     = BYTE_W + 1;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [BYTE_W-1:0]  init_mask_reg;
    logic               decomp_en_reg;
    logic [BYTE_W-1:0]  header_len_reg;
    logic [COUNT_W-1:0] comp_len_reg;
    logic [COUNT_W-1:0] out_len_reg;
    logic [COUNT_W-1:0] guard_reg;

    logic               started_reg, started_next;
    logic [BYTE_W-1:0]  mask_reg, mask_next;
    logic [BYTE_W-1:0]  header_cnt_reg, header_cnt_next;
    logic [COUNT_W-1:0] consumed_reg, consumed_next;
    logic [COUNT_W-1:0] produced_reg, produced_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [3:0]         bits_rem_reg, bits_rem_next;
    logic [WIN_AW-1:0]  acc_reg, acc_next;
    logic [BL_W-1:0]    field_left_reg, field_left_next;
    logic [WIN_AW-1:0]  match_off_reg, match_off_next;
    logic [WIN_AW-1:0]  wptr_reg, wptr_next;
    logic [WIN_AW-1:0]  clear_ptr_reg, clear_ptr_next;
    logic [CNT_W-1:0]   copy_idx_reg, copy_idx_next;
    logic [CNT_W-1:0]   copy_total_reg, copy_total_next;
    logic [RES_AW-1:0]  res_cnt_reg, res_cnt_next;
    logic [RES_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               check_reg, check_next;
    logic               bad_reg, bad_next;
    logic               fwd_reg;
    logic [BYTE_W-1:0]  fwd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_bv_reg, out_bv_next;
    logic               out_status_reg, out_status_next;
    logic               out_done_reg, out_done_next;
    logic               out_last_reg, out_last_next;

    logic               win_we;
    logic [WIN_AW-1:0]  win_waddr;
    logic [BYTE_W-1:0]  win_wdata;
    logic [WIN_AW-1:0]  win_raddr;
    logic [BYTE_W-1:0]  win_rdata;
    logic               res_we;
    logic [RES_AW-1:0]  res_waddr;
    logic [RES_W-1:0]   res_wdata;
    logic [RES_W-1:0]   res_rdata;

    logic               accept;
    logic               filler;
    logic [BYTE_W-1:0]  mask_cur;
    logic [BYTE_W-1:0]  dec_byte;
    logic               pass_through;
    logic               done_now;
    logic               bit_step;
    logic               cur_bit;
    logic [WIN_AW-1:0]  acc_shift;
    logic               lit_end;
    logic               match_end;
    logic               guard_hit;
    logic               copy_stop;
    logic [BYTE_W-1:0]  copy_byte;
    logic               out_load;
    logic               drain_last;

    assign byte_ch.ready = (state_reg == ST_IDLE);
    assign accept        = byte_ch.valid && (state_reg == ST_IDLE);
    assign filler        = (byte_ch.opcode == OPCODE_FILLER);
    assign mask_cur      = started_reg ? mask_reg : init_mask_reg;
    assign dec_byte      = filler ? '0 : (byte_ch.data_byte - mask_cur);
    assign pass_through  = !decomp_en_reg || (header_cnt_reg < header_len_reg);

    assign done_now  = (produced_reg >= out_len_reg);
    assign bit_step  = (state_reg == ST_BITS) && (bits_rem_reg != '0) && !done_now;
    assign cur_bit   = shift_reg[BYTE_W-1];
    assign acc_shift = {acc_reg[WIN_AW-2:0], cur_bit};
    assign lit_end   = bit_step && (phase_reg == PH_LIT) && (field_left_reg == BL_W'(1));
    assign match_end = bit_step && (phase_reg == PH_LEN) && (field_left_reg == BL_W'(1));
    assign guard_hit = ({{(COUNT_W-WIN_AW){1'b0}}, match_off_reg} >= guard_reg);
    assign copy_stop = done_now || (copy_idx_reg == copy_total_reg);
    assign copy_byte = fwd_reg ? fwd_data_reg : win_rdata;

    assign out_load   = (state_reg == ST_DRAIN) && (!out_valid_reg || result_ch.ready);
    assign drain_last = (rd_ptr_reg == (res_cnt_reg - RES_AW'(1)));

    rmlz_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (BYTE_W)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (win_waddr),
        .wr_data (win_wdata),
        .rd_addr (win_raddr),
        .rd_data (win_rdata)
    );

    rmlz_ram #(
        .DEPTH (RES_DEPTH),
        .WIDTH (RES_W)
    ) u_results (
        .clk     (clk),
        .wr_en   (res_we),
        .wr_addr (res_waddr),
        .wr_data (res_wdata),
        .rd_addr (rd_ptr_next),
        .rd_data (res_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_mask_reg  <= '0;
            decomp_en_reg  <= 1'b1;
            header_len_reg <= '0;
            comp_len_reg   <= '0;
            out_len_reg    <= '0;
            guard_reg      <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INITIAL_MASK:      init_mask_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_DECOMPRESS_ENABLE: decomp_en_reg  <= cfg_wdata[0];
                REG_HEADER_LENGTH:     header_len_reg <= cfg_wdata[BYTE_W-1:0];
                REG_COMPRESSED_LENGTH: comp_len_reg   <= cfg_wdata[COUNT_W-1:0];
                REG_OUTPUT_LENGTH:     out_len_reg    <= cfg_wdata[COUNT_W-1:0];
                REG_COPY_GUARD_LIMIT:  guard_reg      <= cfg_wdata[COUNT_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_ptr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pass_through ? ST_DRAIN_START : ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (bits_rem_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (match_end)
                begin
                    state_next = ST_COPY_START;
                end
            end
            ST_COPY_START:
            begin
                state_next = (done_now || guard_hit) ? ST_BITS : ST_COPY;
            end
            ST_COPY:
            begin
                if (copy_stop)
                begin
                    state_next = ST_BITS;
                end
            end
            ST_FINISH:
            begin
                if ((res_cnt_reg == '0) && !check_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DRAIN_START;
                end
            end
            ST_DRAIN_START:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_load && drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        started_next    = started_reg;
        mask_next       = mask_reg;
        header_cnt_next = header_cnt_reg;
        consumed_next   = consumed_reg;
        produced_next   = produced_reg;
        shift_next      = shift_reg;
        bits_rem_next   = bits_rem_reg;
        acc_next        = acc_reg;
        field_left_next = field_left_reg;
        match_off_next  = match_off_reg;
        wptr_next       = wptr_reg;
        clear_ptr_next  = clear_ptr_reg;
        copy_idx_next   = copy_idx_reg;
        copy_total_next = copy_total_reg;
        res_cnt_next    = res_cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        check_next      = check_reg;
        bad_next        = bad_reg;
        win_we          = 1'b0;
        win_waddr       = wptr_reg;
        win_wdata       = '0;
        win_raddr       = match_off_reg;
        res_we          = 1'b0;
        res_waddr       = res_cnt_reg;
        res_wdata       = '0;

        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                win_we         = 1'b1;
                win_waddr      = clear_ptr_reg;
                clear_ptr_next = clear_ptr_reg + WIN_AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    started_next = 1'b1;
                    mask_next    = filler ? mask_cur : (mask_cur + MASK_STEP);
                    check_next   = decomp_en_reg && !filler && byte_ch.last_byte;
                    bad_next     = decomp_en_reg && !filler && byte_ch.last_byte
                                   && (dec_byte != END_MARK_ZERO)
                                   && (dec_byte != END_MARK_HIGH);
                    res_cnt_next = '0;
                    rd_ptr_next  = '0;
                    if (pass_through)
                    begin
                        res_we       = 1'b1;
                        res_waddr    = '0;
                        res_wdata    = {1'b1, dec_byte};
                        res_cnt_next = RES_AW'(1);
                        if (decomp_en_reg)
                        begin
                            header_cnt_next = header_cnt_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        if (consumed_reg < comp_len_reg)
                        begin
                            consumed_next = consumed_reg + COUNT_W'(1);
                            shift_next    = dec_byte;
                        end
                        else
                        begin
                            shift_next = '0;
                        end
                        bits_rem_next = 4'd8;
                    end
                end
            end
            ST_BITS:
            begin
                if (bits_rem_reg != '0)
                begin
                    shift_next    = {shift_reg[BYTE_W-2:0], 1'b0};
                    bits_rem_next = bits_rem_reg - 4'd1;
                end
                if (bit_step)
                begin
                    case (phase_reg)
                        PH_FLAG:
                        begin
                            acc_next = '0;
                            if (cur_bit)
                            begin
                                phase_next      = PH_LIT;
                                field_left_next = BL_W'(LITERAL_BITS);
                            end
                            else
                            begin
                                phase_next      = PH_OFF;
                                field_left_next = BL_W'(WIN_AW);
                            end
                        end
                        PH_LIT:
                        begin
                            acc_next        = acc_shift;
                            field_left_next = field_left_reg - BL_W'(1);
                            if (lit_end)
                            begin
                                phase_next    = PH_FLAG;
                                win_we        = 1'b1;
                                win_wdata     = acc_shift[BYTE_W-1:0];
                                res_we        = 1'b1;
                                res_wdata     = {1'b1, acc_shift[BYTE_W-1:0]};
                                res_cnt_next  = res_cnt_reg + RES_AW'(1);
                                wptr_next     = wptr_reg + WIN_AW'(1);
                                produced_next = produced_reg + COUNT_W'(1);
                            end
                        end
                        PH_OFF:
                        begin
                            acc_next = acc_shift;
                            if (field_left_reg != '0)
                            begin
                                field_left_next = field_left_reg - BL_W'(1);
                            end
                            if (field_left_reg == BL_W'(1))
                            begin
                                match_off_next  = acc_shift;
                                acc_next        = '0;
                                phase_next      = PH_LEN;
                                field_left_next = BL_W'(LENGTH_FIELD_BITS);
                            end
                        end
                        PH_LEN:
                        begin
                            acc_next = acc_shift;
                            if (field_left_reg != '0)
                            begin
                                field_left_next = field_left_reg - BL_W'(1);
                            end
                            if (match_end)
                            begin
                                phase_next      = PH_FLAG;
                                copy_idx_next   = '0;
                                copy_total_next = CNT_W'(acc_shift[LENGTH_FIELD_BITS-1:0])
                                                  + CNT_W'(MATCH_MIN_LEN);
                            end
                        end
                        default:
                        begin
                            phase_next = PH_FLAG;
                        end
                    endcase
                end
            end
            ST_COPY_START:
            begin
                win_raddr = match_off_reg + WIN_AW'(copy_idx_reg);
            end
            ST_COPY:
            begin
                win_raddr = match_off_reg + WIN_AW'(copy_idx_reg + CNT_W'(1));
                if (!copy_stop)
                begin
                    win_we        = 1'b1;
                    win_wdata     = copy_byte;
                    res_we        = 1'b1;
                    res_wdata     = {1'b1, copy_byte};
                    res_cnt_next  = res_cnt_reg + RES_AW'(1);
                    wptr_next     = wptr_reg + WIN_AW'(1);
                    produced_next = produced_reg + COUNT_W'(1);
                    copy_idx_next = copy_idx_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if ((res_cnt_reg == '0) && check_reg)
                begin
                    res_we       = 1'b1;
                    res_waddr    = '0;
                    res_wdata    = '0;
                    res_cnt_next = RES_AW'(1);
                end
                rd_ptr_next = '0;
            end
            ST_DRAIN_START:
            begin
                rd_ptr_next = '0;
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = res_rdata[BYTE_W-1:0];
                    out_bv_next     = res_rdata[BYTE_W];
                    out_status_next = bad_reg;
                    out_done_next   = done_now;
                    out_last_next   = drain_last;
                    rd_ptr_next     = rd_ptr_reg + RES_AW'(1);
                end
            end
            default:
            begin
                rd_ptr_next = rd_ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_FLAG;
            started_reg    <= 1'b0;
            mask_reg       <= '0;
            header_cnt_reg <= '0;
            consumed_reg   <= '0;
            produced_reg   <= '0;
            shift_reg      <= '0;
            bits_rem_reg   <= '0;
            acc_reg        <= '0;
            field_left_reg <= '0;
            match_off_reg  <= '0;
            wptr_reg       <= WIN_AW'(1);
            clear_ptr_reg  <= '0;
            copy_idx_reg   <= '0;
            copy_total_reg <= '0;
            res_cnt_reg    <= '0;
            rd_ptr_reg     <= '0;
            check_reg      <= 1'b0;
            bad_reg        <= 1'b0;
            fwd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            started_reg    <= started_next;
            mask_reg       <= mask_next;
            header_cnt_reg <= header_cnt_next;
            consumed_reg   <= consumed_next;
            produced_reg   <= produced_next;
            shift_reg      <= shift_next;
            bits_rem_reg   <= bits_rem_next;
            acc_reg        <= acc_next;
            field_left_reg <= field_left_next;
            match_off_reg  <= match_off_next;
            wptr_reg       <= wptr_next;
            clear_ptr_reg  <= clear_ptr_next;
            copy_idx_reg   <= copy_idx_next;
            copy_total_reg <= copy_total_next;
            res_cnt_reg    <= res_cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            check_reg      <= check_next;
            bad_reg        <= bad_next;
            fwd_reg        <= win_we && (win_waddr == win_raddr);
            out_valid_reg  <= out_valid_next;
        end
    end

    // A window read that meets a write to the same entry takes the written byte.
    always_ff @(posedge clk)
    begin
        fwd_data_reg   <= win_wdata;
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
        out_last_reg   <= out_last_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.out_byte    = out_byte_reg;
    assign result_ch.byte_valid  = out_bv_reg;
    assign result_ch.status      = out_status_reg;
    assign result_ch.output_done = out_done_reg;
    assign result_ch.run_last    = out_last_reg;

endmodule

[test/rolling_mask_lzss_decoder_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling mask LZSS decoder core testbench
// Feeds encrypted file bytes and filler items through the byte channel,
// predicts every result from a model of the mask, header pass-through, bit
// reader and history window, and compares each result transfer field by field.
// Register settings change between phases while the core is idle. Both
// channels idle at random, with one phase that runs without any idling.
// ----------------------------------------------------------------------------
module rolling_mask_lzss_decoder_core_test;
    import rmlz_pkg::*;

    localparam int WIN_DEPTH     = WINDOW_DEPTH_DEF;
    localparam int OFFSET_BITS   = $clog2(WINDOW_DEPTH_DEF);
    localparam int LEN_BITS      = LENGTH_FIELD_BITS_DEF;
    localparam int IDLE_PCT      = 26;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 5000000;

    localparam logic [OFFSET_BITS-1:0] LEN_MASK     = OFFSET_BITS'((1 << LEN_BITS) - 1);
    localparam logic [OFFSET_BITS-1:0] LITERAL_MASK = OFFSET_BITS'((1 << LITERAL_BITS) - 1);
    localparam logic [COUNT_W-1:0]     COUNT_MAX    = '1;

    typedef struct packed {
        logic             opcode;
        logic [BYTE_W-1:0] data_byte;
        logic             last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              status;
        logic              output_done;
        logic              run_last;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rmlz_byte_if   byte_ch ();
    rmlz_result_if result_ch ();

    rolling_mask_lzss_decoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [BYTE_W-1:0]  mask_start  = '0;
    logic               unpack_on   = 1'b1;
    logic [BYTE_W-1:0]  hdr_len     = '0;
    logic [COUNT_W-1:0] packed_len  = '0;
    logic [COUNT_W-1:0] payload_len = '0;
    logic [COUNT_W-1:0] guard_len   = COUNT_MAX;

    logic                   mask_loaded = 1'b0;
    logic [BYTE_W-1:0]      mask_reg    = '0;
    logic [BYTE_W-1:0]      hdr_count   = '0;
    logic [COUNT_W-1:0]     used_count  = '0;
    logic [COUNT_W-1:0]     made_count  = '0;
    phase_t                 tok_phase   = PH_FLAG;
    logic [OFFSET_BITS-1:0] field_acc   = '0;
    logic [3:0]             bits_left   = '0;
    logic [OFFSET_BITS-1:0] match_off   = '0;
    logic [BYTE_W-1:0]      history [0:WIN_DEPTH-1];
    logic [OFFSET_BITS-1:0] wr_ptr      = OFFSET_BITS'(1);
    logic [BYTE_W-1:0]      fresh_bytes [$];

    byte_item_t  pending_bytes [$];
    result_t     expected_results [$];
    bit          bit_queue [$];
    logic [7:0]  enc_mask = '0;
    byte_item_t  drive_item;
    result_t     seen_result;
    result_t     want_result;
    bit          byte_fire = 1'b0;
    bit          calm = 1'b0;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          status_only_seen = 0;
    int          done_seen = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string fmt_result(result_t r);
        return $sformatf("byte %02h valid %0d status %0d done %0d last %0d",
                         r.out_byte, r.byte_valid, r.status, r.output_done, r.run_last);
    endfunction

    task automatic note_error(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic void store_byte(logic [BYTE_W-1:0] value);
        fresh_bytes.push_back(value);
        history[wr_ptr] = value;
        wr_ptr = wr_ptr + OFFSET_BITS'(1);
        made_count = made_count + COUNT_W'(1);
    endfunction

    function automatic void copy_from_history(logic [LEN_BITS-1:0] len);
        logic [OFFSET_BITS-1:0] src;
        for (int i = 0; i < int'(len) + MATCH_MIN_LEN; i++)
        begin
            if (made_count >= payload_len || match_off >= guard_len)
            begin
                break;
            end
            src = match_off + OFFSET_BITS'(i);
            store_byte(history[src]);
        end
    endfunction

    function automatic void take_bit(logic b);
        if (made_count >= payload_len)
        begin
            return;
        end
        case (tok_phase)
            PH_FLAG:
            begin
                field_acc = '0;
                if (b)
                begin
                    tok_phase = PH_LIT;
                    bits_left = 4'(LITERAL_BITS);
                end
                else
                begin
                    tok_phase = PH_OFF;
                    bits_left = 4'(OFFSET_BITS);
                end
            end
            PH_LIT:
            begin
                field_acc = {field_acc[OFFSET_BITS-2:0], b} & LITERAL_MASK;
                bits_left = bits_left - 4'd1;
                if (bits_left == 0)
                begin
                    store_byte(field_acc[BYTE_W-1:0]);
                    tok_phase = PH_FLAG;
                end
            end
            PH_OFF:
            begin
                field_acc = {field_acc[OFFSET_BITS-2:0], b};
                if (bits_left != 0)
                begin
                    bits_left = bits_left - 4'd1;
                end
                if (bits_left == 0)
                begin
                    match_off = field_acc;
                    field_acc = '0;
                    tok_phase = PH_LEN;
                    bits_left = 4'(LEN_BITS);
                end
            end
            default:
            begin
                field_acc = {field_acc[OFFSET_BITS-2:0], b} & LEN_MASK;
                if (bits_left != 0)
                begin
                    bits_left = bits_left - 4'd1;
                end
                if (bits_left == 0)
                begin
                    copy_from_history(field_acc[LEN_BITS-1:0]);
                    tok_phase = PH_FLAG;
                end
            end
        endcase
    endfunction

    function automatic void decode_byte(byte_item_t item);
        logic [BYTE_W-1:0] plain;
        logic              checked;
        logic              bad_end;
        result_t           res;
        plain = '0;
        checked = 1'b0;
        bad_end = 1'b0;
        fresh_bytes.delete();
        if (!mask_loaded)
        begin
            mask_reg = mask_start;
            mask_loaded = 1'b1;
        end
        if (item.opcode == OPCODE_FILE)
        begin
            plain = item.data_byte - mask_reg;
            mask_reg = mask_reg + MASK_STEP;
        end
        if (!unpack_on)
        begin
            fresh_bytes.push_back(plain);
        end
        else
        begin
            if (item.opcode == OPCODE_FILE && item.last_byte)
            begin
                checked = 1'b1;
                bad_end = (plain != END_MARK_ZERO) && (plain != END_MARK_HIGH);
            end
            if (hdr_count < hdr_len)
            begin
                fresh_bytes.push_back(plain);
                hdr_count = hdr_count + 8'd1;
            end
            else
            begin
                if (used_count < packed_len)
                begin
                    used_count = used_count + COUNT_W'(1);
                end
                else
                begin
                    plain = '0;
                end
                for (int i = BYTE_W - 1; i >= 0; i--)
                begin
                    take_bit(plain[i]);
                end
            end
        end
        res.status = bad_end;
        res.output_done = (made_count >= payload_len);
        if (fresh_bytes.size() == 0)
        begin
            if (checked)
            begin
                res.out_byte = '0;
                res.byte_valid = 1'b0;
                res.run_last = 1'b1;
                expected_results.push_back(res);
            end
        end
        else
        begin
            for (int k = 0; k < fresh_bytes.size(); k++)
            begin
                res.out_byte = fresh_bytes[k];
                res.byte_valid = 1'b1;
                res.run_last = (k == fresh_bytes.size() - 1);
                expected_results.push_back(res);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        byte_fire = rst_n && byte_ch.valid && byte_ch.ready;
        if (byte_fire)
        begin
            decode_byte({byte_ch.opcode, byte_ch.data_byte, byte_ch.last_byte});
            bytes_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!byte_ch.valid || byte_fire))
        begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drive_item = pending_bytes.pop_front();
                byte_ch.valid <= 1'b1;
                byte_ch.opcode <= drive_item.opcode;
                byte_ch.data_byte <= drive_item.data_byte;
                byte_ch.last_byte <= drive_item.last_byte;
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_result.out_byte = result_ch.out_byte;
            seen_result.byte_valid = result_ch.byte_valid;
            seen_result.status = result_ch.status;
            seen_result.output_done = result_ch.output_done;
            seen_result.run_last = result_ch.run_last;
            results_seen++;
            if (seen_result.byte_valid === 1'b0)
            begin
                status_only_seen++;
            end
            if (seen_result.output_done === 1'b1)
            begin
                done_seen++;
            end
            if (expected_results.size() == 0)
            begin
                note_error($sformatf("unexpected result: %s", fmt_result(seen_result)));
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (seen_result.out_byte !== want_result.out_byte
                    || seen_result.byte_valid !== want_result.byte_valid
                    || seen_result.status !== want_result.status
                    || seen_result.output_done !== want_result.output_done
                    || seen_result.run_last !== want_result.run_last)
                begin
                    note_error($sformatf("result %0d: expected %s, got %s", results_seen,
                                         fmt_result(want_result), fmt_result(seen_result)));
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_INITIAL_MASK:      mask_start = value[BYTE_W-1:0];
            REG_DECOMPRESS_ENABLE: unpack_on = value[0];
            REG_HEADER_LENGTH:     hdr_len = value[BYTE_W-1:0];
            REG_COMPRESSED_LENGTH: packed_len = value;
            REG_OUTPUT_LENGTH:     payload_len = value;
            REG_COPY_GUARD_LIMIT:  guard_len = value;
            default:               ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle;
        int waited;
        waited = 0;
        while ((pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            note_error($sformatf("%0d results still outstanding", expected_results.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_item(logic opcode, logic [BYTE_W-1:0] data, logic last);
        byte_item_t item;
        item.opcode = opcode;
        item.data_byte = data;
        item.last_byte = last;
        pending_bytes.push_back(item);
        if (opcode == OPCODE_FILE)
        begin
            enc_mask = enc_mask + MASK_STEP;
        end
    endtask

    task automatic queue_plain(logic [BYTE_W-1:0] plain, logic last);
        queue_item(OPCODE_FILE, plain + enc_mask, last);
    endtask

    task automatic push_bits(logic [15:0] value, int count);
        for (int i = count - 1; i >= 0; i--)
        begin
            bit_queue.push_back(value[i]);
        end
    endtask

    task automatic add_literal(logic [BYTE_W-1:0] value);
        push_bits(16'd1, 1);
        push_bits(16'(value), LITERAL_BITS);
    endtask

    task automatic add_match(logic [OFFSET_BITS-1:0] off, logic [LEN_BITS-1:0] len);
        push_bits(16'd0, 1);
        push_bits(16'(off), OFFSET_BITS);
        push_bits(16'(len), LEN_BITS);
    endtask

    function automatic logic [BYTE_W-1:0] pop_plain();
        logic [BYTE_W-1:0] value;
        value = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            value = {value[BYTE_W-2:0], bit_queue.pop_front()};
        end
        return value;
    endfunction

    task automatic queue_stream(int count);
        int                     pick;
        logic [OFFSET_BITS-1:0] off;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                queue_item(OPCODE_FILLER, 8'($urandom), $urandom_range(0, 99) < 20);
            end
            else
            begin
                while (bit_queue.size() < BYTE_W)
                begin
                    if ($urandom_range(0, 99) < 45)
                    begin
                        add_literal(8'($urandom));
                    end
                    else
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                            off = OFFSET_BITS'($urandom_range(0, 300));
                        else if (pick < 8)
                            off = OFFSET_BITS'($urandom);
                        else if (pick == 8)
                            off = '1;
                        else
                            off = '0;
                        add_match(off, LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1)));
                    end
                end
                queue_plain(pop_plain(), $urandom_range(0, 99) < 10);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            history[i] = '0;
        end
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.opcode = OPCODE_FILE;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end

        // Decrypt-only pass with the highest start mask.
        write_reg(REG_INITIAL_MASK, 24'hFF);
        write_reg(REG_DECOMPRESS_ENABLE, 24'd0);
        enc_mask = 8'hFF;
        queue_item(OPCODE_FILE, 8'h00, 1'b0);
        queue_item(OPCODE_FILE, 8'hFF, 1'b1);
        queue_item(OPCODE_FILLER, 8'hFF, 1'b1);
        queue_item(OPCODE_FILLER, 8'h00, 1'b0);
        queue_item(OPCODE_FILE, 8'h5A, 1'b0);
        wait_idle();

        // Header pass-through, then literals and matches at the field extremes.
        write_reg(REG_DECOMPRESS_ENABLE, 24'd1);
        write_reg(REG_HEADER_LENGTH, 24'd3);
        write_reg(REG_COMPRESSED_LENGTH, COUNT_MAX);
        write_reg(REG_OUTPUT_LENGTH, COUNT_MAX);
        write_reg(REG_COPY_GUARD_LIMIT, COUNT_MAX);
        queue_plain(8'hA5, 1'b0);
        queue_item(OPCODE_FILLER, 8'h3C, 1'b1);
        queue_plain(END_MARK_HIGH, 1'b1);
        add_literal(8'h00);
        add_literal(8'hFF);
        add_match(OFFSET_BITS'(1), LEN_BITS'(0));
        add_match(OFFSET_BITS'(2), '1);
        add_match('1, '1);
        add_match(OFFSET_BITS'(0), LEN_BITS'(0));
        add_literal(END_MARK_HIGH);
        while (bit_queue.size() >= BYTE_W)
        begin
            queue_plain(pop_plain(), 1'b0);
        end
        wait_idle();

        write_reg(REG_HEADER_LENGTH, 24'd0);
        write_reg(REG_COPY_GUARD_LIMIT, 24'h001000);
        queue_stream(40);
        wait_idle();

        write_reg(REG_COPY_GUARD_LIMIT, COUNT_MAX);
        calm = 1'b1;
        queue_stream(35);
        wait_idle();
        calm = 1'b0;

        write_reg(REG_COPY_GUARD_LIMIT, 24'd0);
        queue_stream(10);
        wait_idle();

        // Run past the compressed length into zero bits and past the output length.
        write_reg(REG_COPY_GUARD_LIMIT, COUNT_MAX);
        write_reg(REG_COMPRESSED_LENGTH, used_count + 24'd5);
        write_reg(REG_OUTPUT_LENGTH, made_count + 24'd40);
        queue_stream(15);
        wait_idle();

        write_reg(REG_DECOMPRESS_ENABLE, 24'd0);
        write_reg(REG_INITIAL_MASK, 24'd0);
        write_reg(REG_HEADER_LENGTH, 24'hFF);
        queue_stream(8);
        wait_idle();

        write_reg(REG_DECOMPRESS_ENABLE, 24'd1);
        write_reg(REG_COMPRESSED_LENGTH, 24'd0);
        write_reg(REG_OUTPUT_LENGTH, 24'd0);
        queue_stream(12);
        wait_idle();

        $display("Sent %0d byte transfers across eight register settings and checked %0d results,",
                 bytes_sent, results_seen);
        $display("%0d of them status-only and %0d with the output length reached; %0d errors.",
                 status_only_seen, done_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("rolling_mask_lzss_decoder_core: match");
        end
        else
        begin
            $display("rolling_mask_lzss_decoder_core: mismatch");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("rolling_mask_lzss_decoder_core: mismatch");
        $finish;
    end

endmodule
